// ===== rtl/core/dhps_pkg.sv =====
package dhps_pkg;

    localparam int CMD_W      = 16;
    localparam int MS_W       = 16;
    localparam int SPEED_W    = 15;
    localparam int DUTY_W     = 16;
    localparam int SLEW_W     = 20;
    localparam int IDLE_W     = 17;
    localparam int PROD_W     = SLEW_W + MS_W;
    localparam int DIV_NUM_W  = PROD_W + 1;
    localparam int DIV_DEN_W  = 16;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);
    localparam int STEP_W     = 27;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SLEW_W;

    localparam logic [IDLE_W-1:0]    IDLE_SAT   = {IDLE_W{1'b1}};
    localparam logic [DIV_DEN_W-1:0] MS_PER_S   = DIV_DEN_W'(1000);
    localparam logic [DIV_NUM_W-1:0] STEP_ROUND = DIV_NUM_W'(500);

    localparam logic [SPEED_W-1:0] RST_DEADBAND  = '0;
    localparam logic [SPEED_W-1:0] RST_MAX_SPEED = SPEED_W'(2560);
    localparam logic [DUTY_W-1:0]  RST_RANGE     = DUTY_W'(255);
    localparam logic [SLEW_W-1:0]  RST_SLEW      = '0;
    localparam logic [MS_W-1:0]    RST_WD_LIMIT  = MS_W'(500);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEADBAND   = 3'd0,
        CFG_MAX_SPEED  = 3'd1,
        CFG_RANGE      = 3'd2,
        CFG_SLEW       = 3'd3,
        CFG_INVERT     = 3'd4,
        CFG_BRAKE      = 3'd5,
        CFG_WD_LIMIT   = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [SPEED_W-1:0] deadband_speed;
        logic [SPEED_W-1:0] max_speed;
        logic [DUTY_W-1:0]  duty_range;
        logic [SLEW_W-1:0]  slew_per_second;
        logic [1:0]         invert_mask;
        logic               brake_when_stopped;
        logic [MS_W-1:0]    watchdog_limit_ms;
    } t_cfg;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] num;
        logic [DIV_DEN_W-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_NUM_W-1:0] quot;
    } t_div_rsp;

endpackage

// ===== rtl/core/dhps_cmd_if.sv =====
interface dhps_cmd_if;
    logic                               valid;
    logic                               ready;
    logic signed [dhps_pkg::CMD_W-1:0]  left_command;
    logic signed [dhps_pkg::CMD_W-1:0]  right_command;
    logic        [dhps_pkg::MS_W-1:0]   period_ms;

    modport source (
        output valid, left_command, right_command, period_ms,
        input  ready
    );
    modport sink (
        input  valid, left_command, right_command, period_ms,
        output ready
    );
endinterface

// ===== rtl/core/dhps_drv_if.sv =====
interface dhps_drv_if;
    logic                            valid;
    logic                            ready;
    logic [dhps_pkg::DUTY_W-1:0]     left_duty;
    logic                            left_in_a;
    logic                            left_in_b;
    logic [dhps_pkg::DUTY_W-1:0]     right_duty;
    logic                            right_in_a;
    logic                            right_in_b;
    logic                            watchdog_tripped;

    modport source (
        output valid, left_duty, left_in_a, left_in_b,
               right_duty, right_in_a, right_in_b, watchdog_tripped,
        input  ready
    );
    modport sink (
        input  valid, left_duty, left_in_a, left_in_b,
               right_duty, right_in_a, right_in_b, watchdog_tripped,
        output ready
    );
endinterface

// ===== rtl/core/dhps_cfg.sv =====
module dhps_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_we,
    input  logic [dhps_pkg::CFG_IDX_W-1:0]     i_idx,
    input  logic [dhps_pkg::CFG_DATA_W-1:0]    i_data,
    output dhps_pkg::t_cfg                     o_cfg
);

    dhps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.deadband_speed     <= dhps_pkg::RST_DEADBAND;
            r_cfg.max_speed          <= dhps_pkg::RST_MAX_SPEED;
            r_cfg.duty_range         <= dhps_pkg::RST_RANGE;
            r_cfg.slew_per_second    <= dhps_pkg::RST_SLEW;
            r_cfg.invert_mask        <= '0;
            r_cfg.brake_when_stopped <= 1'b0;
            r_cfg.watchdog_limit_ms  <= dhps_pkg::RST_WD_LIMIT;
        end else if (i_we) begin
            unique case (i_idx)
                dhps_pkg::CFG_DEADBAND: begin
                    r_cfg.deadband_speed <= i_data[dhps_pkg::SPEED_W-1:0];
                end
                dhps_pkg::CFG_MAX_SPEED: begin
                    r_cfg.max_speed <= i_data[dhps_pkg::SPEED_W-1:0];
                end
                dhps_pkg::CFG_RANGE: begin
                    r_cfg.duty_range <= i_data[dhps_pkg::DUTY_W-1:0];
                end
                dhps_pkg::CFG_SLEW: begin
                    r_cfg.slew_per_second <= i_data[dhps_pkg::SLEW_W-1:0];
                end
                dhps_pkg::CFG_INVERT: begin
                    r_cfg.invert_mask <= i_data[1:0];
                end
                dhps_pkg::CFG_BRAKE: begin
                    r_cfg.brake_when_stopped <= i_data[0];
                end
                dhps_pkg::CFG_WD_LIMIT: begin
                    r_cfg.watchdog_limit_ms <= i_data[dhps_pkg::MS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/core/dhps_div.sv =====
module dhps_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dhps_pkg::t_div_req  i_req,
    output dhps_pkg::t_div_rsp  o_rsp
);

    logic                               r_busy;
    logic                               r_done;
    logic [dhps_pkg::DIV_CNT_W-1:0]     r_cnt;
    logic [dhps_pkg::DIV_NUM_W-1:0]     r_acc;
    logic [dhps_pkg::DIV_DEN_W-1:0]     r_rem;
    logic [dhps_pkg::DIV_DEN_W-1:0]     r_den;
    logic [dhps_pkg::DIV_DEN_W:0]       trial;
    logic                               fits;

    assign trial = {r_rem, r_acc[dhps_pkg::DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= dhps_pkg::DIV_CNT_W'(dhps_pkg::DIV_NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == dhps_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= i_req.num;
            r_den <= i_req.den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[dhps_pkg::DIV_NUM_W-2:0], fits};
            if (fits) begin
                r_rem <= dhps_pkg::DIV_DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[dhps_pkg::DIV_DEN_W-1:0];
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_acc;

endmodule

// ===== rtl/core/dual_hbridge_pwm_drive_shaper_top.sv =====
// Takes one beat of left and right speed commands with the period length and
// returns one beat of duty counts and bridge pin levels for both wheels. One
// command beat is taken at a time; the block is busy until its result beat has
// been taken. The result beat comes from three passes through the shared
// 37-step restoring divider (the slew step, then the duty of each wheel) and
// the handling of each wheel. A wheel inside the deadband or at full speed
// skips its pass, and a beat on which the watchdog trips is offered in the
// cycle right after it is taken. After the result beat has been taken the
// block returns to idle before it takes the next command beat.
// Configuration writes should only be made while no beat is in flight.
module dual_hbridge_pwm_drive_shaper_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    dhps_cmd_if.sink                           i_cmd,
    dhps_drv_if.source                         o_drv,
    input  logic                               i_cfg_we,
    input  logic [dhps_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [dhps_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_MUL_STEP  = 10'b0000000010,
        S_DIV_STEP  = 10'b0000000100,
        S_WAIT_STEP = 10'b0000001000,
        S_WHEEL     = 10'b0000010000,
        S_MUL_DUTY  = 10'b0000100000,
        S_DIV_DUTY  = 10'b0001000000,
        S_WAIT_DUTY = 10'b0010000000,
        S_SLEW      = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } t_state;

    localparam int DW = dhps_pkg::DUTY_W;
    localparam int CW = dhps_pkg::CMD_W;
    localparam int SW = dhps_pkg::STEP_W;

    dhps_pkg::t_cfg     cfg;
    dhps_pkg::t_div_req div_req;
    dhps_pkg::t_div_rsp div_rsp;

    t_state                          r_state, n_state;
    logic                            r_wheel, n_wheel;
    logic signed [CW-1:0]            r_cmd [2];
    logic signed [CW-1:0]            n_cmd [2];
    logic signed [CW-1:0]            r_prev_cmd [2];
    logic signed [CW-1:0]            n_prev_cmd [2];
    logic [dhps_pkg::MS_W-1:0]       r_ms, n_ms;
    logic [dhps_pkg::IDLE_W-1:0]     r_idle, n_idle;
    logic [DW-1:0]                   r_prev_duty [2];
    logic [DW-1:0]                   n_prev_duty [2];
    logic [dhps_pkg::PROD_W-1:0]     r_prod, n_prod;
    logic [SW-1:0]                   r_step, n_step;
    logic [DW-1:0]                   r_mag, n_mag;
    logic                            r_neg, n_neg;
    logic [DW-1:0]                   r_target, n_target;
    logic [DW-1:0]                   r_duty [2];
    logic [DW-1:0]                   n_duty [2];
    logic                            r_pin_a [2];
    logic                            n_pin_a [2];
    logic                            r_pin_b [2];
    logic                            n_pin_b [2];
    logic                            r_trip, n_trip;

    logic                            cmd_active;
    logic [dhps_pkg::IDLE_W:0]       idle_sum;
    logic [dhps_pkg::IDLE_W-1:0]     idle_next;
    logic                            trip;

    logic signed [CW:0]              cmd_ext;
    logic signed [CW:0]              c_val;
    logic [CW:0]                     c_abs;
    logic                            c_neg;
    logic [DW-1:0]                   mag;
    logic                            in_deadband;

    logic [dhps_pkg::SLEW_W-1:0]     mul_a;
    logic [dhps_pkg::MS_W-1:0]       mul_b;
    logic [dhps_pkg::PROD_W-1:0]     mul_out;

    logic [SW:0]                     prev_ext;
    logic [SW:0]                     target_ext;
    logic [SW:0]                     slew_hi;
    logic [SW:0]                     slew_lo;
    logic [SW:0]                     target_up;
    logic [DW-1:0]                   slew_duty;

    dhps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_idx   (i_cfg_idx),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    dhps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    assign cmd_active = (|i_cmd.left_command) || (|i_cmd.right_command) ||
                        (i_cmd.left_command != r_prev_cmd[0]) ||
                        (i_cmd.right_command != r_prev_cmd[1]);
    assign idle_sum   = {1'b0, r_idle} + (dhps_pkg::IDLE_W + 1)'(i_cmd.period_ms);
    assign idle_next  = cmd_active ? '0 :
                        (idle_sum[dhps_pkg::IDLE_W] ? dhps_pkg::IDLE_SAT
                                                    : idle_sum[dhps_pkg::IDLE_W-1:0]);
    assign trip       = idle_next > dhps_pkg::IDLE_W'(cfg.watchdog_limit_ms);

    assign cmd_ext     = {r_cmd[r_wheel][CW-1], r_cmd[r_wheel]};
    assign c_val       = cfg.invert_mask[r_wheel] ? -cmd_ext : cmd_ext;
    assign c_neg       = c_val[CW];
    assign c_abs       = c_neg ? -c_val : c_val;
    assign mag         = c_abs[DW-1:0];
    assign in_deadband = mag < DW'(cfg.deadband_speed);

    always_comb begin
        if (r_state == S_MUL_STEP) begin
            mul_a = cfg.slew_per_second;
            mul_b = (r_ms == '0) ? dhps_pkg::MS_W'(1) : r_ms;
        end else begin
            mul_a = dhps_pkg::SLEW_W'(r_mag);
            mul_b = cfg.duty_range;
        end
    end
    assign mul_out = dhps_pkg::PROD_W'(mul_a) * dhps_pkg::PROD_W'(mul_b);

    always_comb begin
        div_req.start = (r_state == S_DIV_STEP) || (r_state == S_DIV_DUTY);
        if (r_state == S_DIV_STEP) begin
            div_req.num = {1'b0, r_prod} + dhps_pkg::STEP_ROUND;
            div_req.den = dhps_pkg::MS_PER_S;
        end else begin
            div_req.num = {r_prod, 1'b0} + dhps_pkg::DIV_NUM_W'(cfg.max_speed);
            div_req.den = {cfg.max_speed, 1'b0};
        end
    end

    assign prev_ext   = (SW + 1)'(r_prev_duty[r_wheel]);
    assign target_ext = (SW + 1)'(r_target);
    assign slew_hi    = prev_ext + {1'b0, r_step};
    assign slew_lo    = prev_ext - {1'b0, r_step};
    assign target_up  = target_ext + {1'b0, r_step};

    always_comb begin
        if (r_step == '0) begin
            slew_duty = r_target;
        end else if (target_ext > slew_hi) begin
            slew_duty = slew_hi[DW-1:0];
        end else if (target_up < prev_ext) begin
            slew_duty = slew_lo[DW-1:0];
        end else begin
            slew_duty = r_target;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_cmd       = r_cmd;
        n_prev_cmd  = r_prev_cmd;
        n_ms        = r_ms;
        n_idle      = r_idle;
        n_prev_duty = r_prev_duty;
        n_prod      = r_prod;
        n_step      = r_step;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_target    = r_target;
        n_duty      = r_duty;
        n_pin_a     = r_pin_a;
        n_pin_b     = r_pin_b;
        n_trip      = r_trip;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_cmd[0] = i_cmd.left_command;
                    n_cmd[1] = i_cmd.right_command;
                    n_ms     = i_cmd.period_ms;
                    n_idle   = idle_next;
                    if (cmd_active) begin
                        n_prev_cmd[0] = i_cmd.left_command;
                        n_prev_cmd[1] = i_cmd.right_command;
                    end
                    n_trip = trip;
                    if (trip) begin
                        n_duty[0]  = '0;
                        n_duty[1]  = '0;
                        n_pin_a[0] = 1'b1;
                        n_pin_a[1] = 1'b1;
                        n_pin_b[0] = 1'b1;
                        n_pin_b[1] = 1'b1;
                        n_state    = S_OUT;
                    end else begin
                        n_wheel = 1'b0;
                        n_state = S_MUL_STEP;
                    end
                end
            end
            S_MUL_STEP: begin
                n_prod  = mul_out;
                n_state = S_DIV_STEP;
            end
            S_DIV_STEP: begin
                n_state = S_WAIT_STEP;
            end
            S_WAIT_STEP: begin
                if (div_rsp.done) begin
                    n_step  = div_rsp.quot[SW-1:0];
                    n_state = S_WHEEL;
                end
            end
            S_WHEEL: begin
                n_mag = mag;
                n_neg = c_neg;
                if (in_deadband) begin
                    n_duty[r_wheel]      = '0;
                    n_pin_a[r_wheel]     = cfg.brake_when_stopped;
                    n_pin_b[r_wheel]     = cfg.brake_when_stopped;
                    n_prev_duty[r_wheel] = '0;
                    if (r_wheel) begin
                        n_state = S_OUT;
                    end else begin
                        n_wheel = 1'b1;
                    end
                end else if ((mag == '0) && (cfg.max_speed == '0)) begin
                    n_target = '0;
                    n_state  = S_SLEW;
                end else if (mag >= DW'(cfg.max_speed)) begin
                    n_target = cfg.duty_range;
                    n_state  = S_SLEW;
                end else begin
                    n_state = S_MUL_DUTY;
                end
            end
            S_MUL_DUTY: begin
                n_prod  = mul_out;
                n_state = S_DIV_DUTY;
            end
            S_DIV_DUTY: begin
                n_state = S_WAIT_DUTY;
            end
            S_WAIT_DUTY: begin
                if (div_rsp.done) begin
                    n_target = div_rsp.quot[DW-1:0];
                    n_state  = S_SLEW;
                end
            end
            S_SLEW: begin
                n_duty[r_wheel]      = slew_duty;
                n_pin_a[r_wheel]     = !r_neg;
                n_pin_b[r_wheel]     = r_neg;
                n_prev_duty[r_wheel] = slew_duty;
                if (r_wheel) begin
                    n_state = S_OUT;
                end else begin
                    n_wheel = 1'b1;
                    n_state = S_WHEEL;
                end
            end
            S_OUT: begin
                if (o_drv.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wheel     <= 1'b0;
            r_prev_cmd  <= '{default: '0};
            r_idle      <= '0;
            r_prev_duty <= '{default: '0};
        end else begin
            r_state     <= n_state;
            r_wheel     <= n_wheel;
            r_prev_cmd  <= n_prev_cmd;
            r_idle      <= n_idle;
            r_prev_duty <= n_prev_duty;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_ms     <= n_ms;
        r_prod   <= n_prod;
        r_step   <= n_step;
        r_mag    <= n_mag;
        r_neg    <= n_neg;
        r_target <= n_target;
        r_duty   <= n_duty;
        r_pin_a  <= n_pin_a;
        r_pin_b  <= n_pin_b;
        r_trip   <= n_trip;
    end

    assign i_cmd.ready            = (r_state == S_IDLE);
    assign o_drv.valid            = (r_state == S_OUT);
    assign o_drv.left_duty        = r_duty[0];
    assign o_drv.left_in_a        = r_pin_a[0];
    assign o_drv.left_in_b        = r_pin_b[0];
    assign o_drv.right_duty       = r_duty[1];
    assign o_drv.right_in_a       = r_pin_a[1];
    assign o_drv.right_in_b       = r_pin_b[1];
    assign o_drv.watchdog_tripped = r_trip;

endmodule
